// ----- hw/rtl/capsule_support_point_macros.svh -----
// ---------------------------------------------------------------------------
// capsule support point assertion macros
// concurrent check wrappers, empty when synthesizing
// ---------------------------------------------------------------------------
`ifndef CAPSULE_SUPPORT_POINT_MACROS_SVH
`define CAPSULE_SUPPORT_POINT_MACROS_SVH
`ifndef SYNTHESIS
`define CSP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("capsule_support_point check failed");
`define CSP_ASSERT_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("capsule_support_point reset check failed");
`else
`define CSP_ASSERT(lbl, prop)
`define CSP_ASSERT_RST(lbl, prop)
`endif
`endif

// ----- hw/rtl/csp_pkg.sv -----
// ---------------------------------------------------------------------------
// csp package
// shared widths, register codes and pipeline depths
// ---------------------------------------------------------------------------
package csp_pkg;
	localparam int DirW   = 16;
	localparam int RegW   = 16;
	localparam int PointW = 24;
	localparam int LenW   = 32;
	localparam int SumW   = 64;
	localparam int NumW   = 48;
	localparam int QuotW  = 16;
	localparam int CfgIdxW = 2;

	localparam int SqrtStages = SumW / 2;
	localparam int DivStages  = QuotW;
	localparam int PipeDepth  = 3 + SqrtStages + DivStages;

	localparam logic [CfgIdxW-1:0] CFG_RADIUS_X   = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_RADIUS_Y   = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_RADIUS_Z   = 2'd2;
	localparam logic [CfgIdxW-1:0] CFG_CYL_HEIGHT = 2'd3;

	localparam logic [RegW-1:0] RADIUS_RST = 16'd64;
	localparam logic [RegW-1:0] HEIGHT_RST = 16'd128;

	typedef logic [QuotW:0] ellip_t;
endpackage

// ----- hw/rtl/csp_stream_if.sv -----
// ---------------------------------------------------------------------------
// csp stream interfaces
// direction and point channels with valid/ready
// ---------------------------------------------------------------------------
interface csp_dir_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] dir_x;
	logic signed [15:0] dir_y;
	logic signed [15:0] dir_z;
	modport source (output valid, dir_x, dir_y, dir_z, input ready);
	modport sink (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

interface csp_point_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] point_x;
	logic signed [23:0] point_y;
	logic signed [23:0] point_z;
	modport source (output valid, point_x, point_y, point_z, input ready);
	modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

// ----- hw/rtl/csp_sqrt.sv -----
// ---------------------------------------------------------------------------
// csp square root
// pipelined integer square root, one result bit per stage
// ---------------------------------------------------------------------------
module csp_sqrt (
	input  logic                      clk,
	input  logic                      en,
	input  logic [csp_pkg::SumW-1:0]  v,
	output logic [csp_pkg::LenW-1:0]  root
);
	import csp_pkg::*;

	localparam int RemW = LenW + 3;

	logic [RemW-1:0] rem_q  [SqrtStages];
	logic [LenW-1:0] root_q [SqrtStages];
	logic [SumW-1:0] v_q    [SqrtStages];

	for (genvar i = 0; i < SqrtStages; i++) begin : g_stage
		logic [RemW-1:0] rem_in;
		logic [LenW-1:0] root_in;
		logic [SumW-1:0] v_in;
		logic [RemW-1:0] sh;
		logic [RemW-1:0] trial;
		logic            ge;

		// stage inputs
		if (i == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign v_in    = v;
		end else begin : g_next
			assign rem_in  = rem_q[i-1];
			assign root_in = root_q[i-1];
			assign v_in    = v_q[i-1];
		end

		// bring down two bits, try next root bit
		assign sh    = {rem_in[RemW-3:0], v_in[SumW-1 -: 2]};
		assign trial = {1'b0, root_in, 2'b01};
		assign ge    = sh >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i]  <= ge ? sh - trial : sh;
				root_q[i] <= {root_in[LenW-2:0], ge};
				v_q[i]    <= {v_in[SumW-3:0], 2'b00};
			end
		end
	end

	assign root = root_q[SqrtStages-1];
endmodule

// ----- hw/rtl/csp_div_lane.sv -----
// ---------------------------------------------------------------------------
// csp divider lane
// pipelined restoring divide of one axis numerator by the length
// ---------------------------------------------------------------------------
module csp_div_lane (
	input  logic                     clk,
	input  logic                     en,
	input  logic [csp_pkg::NumW-1:0] num,
	input  logic [csp_pkg::LenW-1:0] len,
	input  logic                     neg,
	output csp_pkg::ellip_t          e
);
	import csp_pkg::*;

	logic [LenW-1:0]  rem_q [DivStages];
	logic [QuotW-1:0] n_q   [DivStages];
	logic [QuotW-1:0] q_q   [DivStages];
	logic [LenW-1:0]  len_q [DivStages];
	logic             neg_q [DivStages];

	for (genvar i = 0; i < DivStages; i++) begin : g_stage
		logic [LenW-1:0]  rem_in;
		logic [QuotW-1:0] n_in;
		logic [QuotW-1:0] q_in;
		logic [LenW-1:0]  len_in;
		logic             neg_in;
		logic [LenW:0]    sh;
		logic [LenW:0]    diff;
		logic             ge;

		// stage inputs
		if (i == 0) begin : g_first
			assign rem_in = num[NumW-1:QuotW];
			assign n_in   = num[QuotW-1:0];
			assign q_in   = '0;
			assign len_in = len;
			assign neg_in = neg;
		end else begin : g_next
			assign rem_in = rem_q[i-1];
			assign n_in   = n_q[i-1];
			assign q_in   = q_q[i-1];
			assign len_in = len_q[i-1];
			assign neg_in = neg_q[i-1];
		end

		// one quotient bit
		assign sh   = {rem_in, n_in[QuotW-1]};
		assign ge   = sh >= {1'b0, len_in};
		assign diff = sh - {1'b0, len_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i] <= ge ? diff[LenW-1:0] : sh[LenW-1:0];
				n_q[i]   <= {n_in[QuotW-2:0], 1'b0};
				q_q[i]   <= {q_in[QuotW-2:0], ge};
				len_q[i] <= len_in;
				neg_q[i] <= neg_in;
			end
		end
	end

	// zero length gives zero, else apply sign
	always_comb begin
		if (len_q[DivStages-1] == '0) begin
			e = '0;
		end else if (neg_q[DivStages-1]) begin
			e = ellip_t'(-{1'b0, q_q[DivStages-1]});
		end else begin
			e = {1'b0, q_q[DivStages-1]};
		end
	end
endmodule

// ----- hw/rtl/capsule_support_point.sv -----
// ---------------------------------------------------------------------------
// capsule support point
// support mapping of a capsule with ellipsoid caps for gjk queries
// ---------------------------------------------------------------------------
// usage:
//   dir_in carries one query direction per beat (signed q8.8 x, y, z);
//   point_out returns one support point per beat (signed q16.8).
//   cfg_we/cfg_idx/cfg_data write radius_x, radius_y, radius_z and
//   cyl_height (indexes 0..3); write only while no beat is in flight.
// pipeline: three multiply and sum stages, 32 square root stages (one
//   root bit each), 16 divider stages (one quotient bit each, one lane
//   per axis) and the merge register that adds or subtracts the half
//   height on y.
// throughput: one beat per cycle unless point_out is held; fully pipelined.
// reset: arst_n clears all valid bits and loads radii of 64 and a height
//   of 128.
// stall: when point_out is held, the whole pipeline freezes and dir_in
//   ready drops in the same cycle; nothing is lost or repeated.
// ---------------------------------------------------------------------------
`include "capsule_support_point_macros.svh"

module capsule_support_point (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [csp_pkg::CfgIdxW-1:0] cfg_idx,
	input  logic [csp_pkg::RegW-1:0]    cfg_data,
	csp_dir_if.sink                     dir_in,
	csp_point_if.source                 point_out
);
	import csp_pkg::*;

	logic [RegW-1:0] radius_x_q, radius_y_q, radius_z_q, cyl_height_q;
	logic            adv;
	logic            out_valid_q;
	logic            vld_q  [PipeDepth];
	logic            yup_q  [PipeDepth];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_x_q   <= RADIUS_RST;
			radius_y_q   <= RADIUS_RST;
			radius_z_q   <= RADIUS_RST;
			cyl_height_q <= HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_RADIUS_X:   radius_x_q   <= cfg_data;
				CFG_RADIUS_Y:   radius_y_q   <= cfg_data;
				CFG_RADIUS_Z:   radius_z_q   <= cfg_data;
				CFG_CYL_HEIGHT: cyl_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance
	assign adv          = !out_valid_q || point_out.ready;
	assign dir_in.ready = adv;

	// valid and y flag line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PipeDepth; i++) vld_q[i] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= dir_in.valid;
			for (int i = 1; i < PipeDepth; i++) vld_q[i] <= vld_q[i-1];
			out_valid_q <= vld_q[PipeDepth-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			yup_q[0] <= (dir_in.dir_y > 0) && (cyl_height_q != '0);
			for (int i = 1; i < PipeDepth; i++) yup_q[i] <= yup_q[i-1];
		end
	end

	// stage 1: magnitudes times radius, radius squared
	logic [DirW-1:0] ad_x, ad_y, ad_z;
	logic [LenW-1:0] p_x_s1, p_y_s1, p_z_s1;
	logic [LenW-1:0] rr_x_s1, rr_y_s1, rr_z_s1;
	logic [DirW-1:0] ad_x_s1, ad_y_s1, ad_z_s1;
	logic [2:0]      neg_s1;

	assign ad_x = dir_in.dir_x[DirW-1] ? DirW'(-dir_in.dir_x) : dir_in.dir_x;
	assign ad_y = dir_in.dir_y[DirW-1] ? DirW'(-dir_in.dir_y) : dir_in.dir_y;
	assign ad_z = dir_in.dir_z[DirW-1] ? DirW'(-dir_in.dir_z) : dir_in.dir_z;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_x_s1  <= radius_x_q * ad_x;
			p_y_s1  <= radius_y_q * ad_y;
			p_z_s1  <= radius_z_q * ad_z;
			rr_x_s1 <= radius_x_q * radius_x_q;
			rr_y_s1 <= radius_y_q * radius_y_q;
			rr_z_s1 <= radius_z_q * radius_z_q;
			ad_x_s1 <= ad_x;
			ad_y_s1 <= ad_y;
			ad_z_s1 <= ad_z;
			neg_s1  <= {dir_in.dir_z[DirW-1], dir_in.dir_y[DirW-1], dir_in.dir_x[DirW-1]};
		end
	end

	// stage 2: squares and numerators
	logic [SumW-1:0] sq_x_s2, sq_y_s2, sq_z_s2;
	logic [NumW-1:0] num_x_s2, num_y_s2, num_z_s2;
	logic [2:0]      neg_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_x_s2  <= p_x_s1 * p_x_s1;
			sq_y_s2  <= p_y_s1 * p_y_s1;
			sq_z_s2  <= p_z_s1 * p_z_s1;
			num_x_s2 <= rr_x_s1 * ad_x_s1;
			num_y_s2 <= rr_y_s1 * ad_y_s1;
			num_z_s2 <= rr_z_s1 * ad_z_s1;
			neg_s2   <= neg_s1;
		end
	end

	// stage 3: squared length
	logic [SumW-1:0] sum_s3;
	logic [NumW-1:0] num_x_s3, num_y_s3, num_z_s3;
	logic [2:0]      neg_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3   <= sq_x_s2 + sq_y_s2 + sq_z_s2;
			num_x_s3 <= num_x_s2;
			num_y_s3 <= num_y_s2;
			num_z_s3 <= num_z_s2;
			neg_s3   <= neg_s2;
		end
	end

	// length, numerators delayed alongside
	logic [LenW-1:0] len;
	logic [NumW-1:0] nx_d [SqrtStages];
	logic [NumW-1:0] ny_d [SqrtStages];
	logic [NumW-1:0] nz_d [SqrtStages];
	logic [2:0]      ng_d [SqrtStages];

	csp_sqrt u_sqrt (
		.clk  (clk),
		.en   (adv),
		.v    (sum_s3),
		.root (len)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_d[0] <= num_x_s3;
			ny_d[0] <= num_y_s3;
			nz_d[0] <= num_z_s3;
			ng_d[0] <= neg_s3;
			for (int i = 1; i < SqrtStages; i++) begin
				nx_d[i] <= nx_d[i-1];
				ny_d[i] <= ny_d[i-1];
				nz_d[i] <= nz_d[i-1];
				ng_d[i] <= ng_d[i-1];
			end
		end
	end

	// divider lanes, one per axis
	ellip_t e_x, e_y, e_z;

	csp_div_lane u_lane_x (
		.clk (clk), .en (adv), .num (nx_d[SqrtStages-1]), .len (len),
		.neg (ng_d[SqrtStages-1][0]), .e (e_x)
	);
	csp_div_lane u_lane_y (
		.clk (clk), .en (adv), .num (ny_d[SqrtStages-1]), .len (len),
		.neg (ng_d[SqrtStages-1][1]), .e (e_y)
	);
	csp_div_lane u_lane_z (
		.clk (clk), .en (adv), .num (nz_d[SqrtStages-1]), .len (len),
		.neg (ng_d[SqrtStages-1][2]), .e (e_z)
	);

	// merge: sign extend and apply half height on y
	logic [PointW-1:0] ex_w, ey_w, ez_w, half_w;
	logic [PointW-1:0] px_q, py_q, pz_q;

	assign ex_w   = {{(PointW-QuotW-1){e_x[QuotW]}}, e_x};
	assign ey_w   = {{(PointW-QuotW-1){e_y[QuotW]}}, e_y};
	assign ez_w   = {{(PointW-QuotW-1){e_z[QuotW]}}, e_z};
	assign half_w = {{(PointW-RegW+1){1'b0}}, cyl_height_q[RegW-1:1]};

	always_ff @(posedge clk) begin
		if (adv) begin
			px_q <= ex_w;
			py_q <= yup_q[PipeDepth-1] ? ey_w + half_w : ey_w - half_w;
			pz_q <= ez_w;
		end
	end

	assign point_out.valid   = out_valid_q;
	assign point_out.point_x = px_q;
	assign point_out.point_y = py_q;
	assign point_out.point_z = pz_q;

	// x radius widened to the point width for the bound check
	logic [PointW-1:0] rad_x_w;
	assign rad_x_w = {{(PointW-RegW){1'b0}}, radius_x_q};

	// checks
	`CSP_ASSERT(a_ready_follows_out, dir_in.ready == (!out_valid_q || point_out.ready))
	`CSP_ASSERT(a_x_bounded, out_valid_q |-> ($signed(px_q) <= $signed(rad_x_w)))
	`CSP_ASSERT(a_x_bounded_neg, out_valid_q |-> ($signed(px_q) >= -$signed(rad_x_w)))
	`CSP_ASSERT(a_freeze_holds, (vld_q[PipeDepth-1] && !adv) |=> vld_q[PipeDepth-1])
	`CSP_ASSERT_RST(a_reset_clears, !arst_n |-> !out_valid_q)
endmodule
